// ----- hw/rtl/lpht_pkg.sv -----
// Types and codes shared by the linear-probing hash table.
`timescale 1ns / 1ps

package lpht_pkg;

   localparam int KEY_W = 32;

   // power of two: the home slot is the low key bits
   localparam int TABLE_SLOTS = 64;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key_hash;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] entry_index;
      logic [4:0] entry_count;
   } rsp_type;

endpackage

// ----- hw/rtl/linear_probe_hash_table_top.sv -----
// Linear-probing hash table: probe sequencer, slot and key memories.
//
//   channel   ports                       handshake
//   request   start, busy, req_payload    taken when start && !busy
//   response  rsp_valid, rsp_payload      one-cycle strobe, cannot be held off
//
// Lookup/insert: the home slot is the low key bits, so probing starts the cycle after
// the request is taken: a slot read and a slot check to reach an empty slot, and a slot
// read, slot check and key check per occupied slot passed, up to TABLE_SLOTS slots.
// Clear: one slot written per cycle over the whole table. Every response strobes the
// cycle after its last step; an unused command strobes the cycle after it is taken.
// After reset the whole slot memory is swept with busy high.
// busy drops in the strobe cycle (an unused command never raises it); no receiver stall.
`timescale 1ns / 1ps

module linear_probe_hash_table_top
   import lpht_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);

   typedef struct packed {
      logic               valid;
      logic [ENTRY_W-1:0] entry;
   } slot_type;

   typedef enum logic [4:0] {
      S_SWEEP    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_SLOT_RD  = 5'b00100,
      S_SLOT_CHK = 5'b01000,
      S_KEY_CHK  = 5'b10000
   } state_type;

   slot_type         slot_mem [TABLE_SLOTS];
   logic [KEY_W-1:0] key_mem  [MAX_ENTRIES];

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [SLOT_W-1:0] probe_slot_ff, probe_slot_in;
   logic [SLOT_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   slot_type         slot_q_ff;
   logic [KEY_W-1:0] key_q_ff;

   logic              slot_we;
   slot_type          slot_wdata;
   logic              key_we;
   logic              entry_live;
   logic [SLOT_W-1:0] slot_step;

   function automatic rsp_type make_rsp(input logic [1:0] status,
                                        input logic [ENTRY_W-1:0] idx,
                                        input logic [CNT_W-1:0] cnt);
      logic [31:0] idx_ext;
      logic [31:0] cnt_ext;
      rsp_type     r;
      idx_ext       = 32'(idx);
      cnt_ext       = 32'(cnt);
      r.status      = status;
      r.entry_index = idx_ext[3:0];
      r.entry_count = cnt_ext[4:0];
      return r;
   endfunction

   assign entry_live = (32'(slot_q_ff.entry) < 32'(count_ff));
   assign slot_step  = (32'(probe_slot_ff) == TABLE_SLOTS - 1) ? '0 : probe_slot_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      probe_slot_in = probe_slot_ff;
      probe_cnt_in  = probe_cnt_ff;
      count_in      = count_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      slot_we       = 1'b0;
      slot_wdata    = '0;
      key_we        = 1'b0;

      case (state_ff)
         S_SWEEP: begin
            slot_we       = 1'b1;
            probe_slot_in = slot_step;
            if (32'(probe_slot_ff) == TABLE_SLOTS - 1) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(STATUS_OK, '0, '0);
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = req_payload.cmd;
               key_in = req_payload.key_hash;
               case (req_payload.cmd)
                  CMD_CLEAR: begin
                     state_in      = S_SWEEP;
                     clr_rsp_in    = 1'b1;
                     probe_slot_in = '0;
                     count_in      = '0;
                  end
                  CMD_LOOKUP, CMD_INSERT: begin
                     state_in      = S_SLOT_RD;
                     probe_slot_in = req_payload.key_hash[SLOT_W-1:0];
                     probe_cnt_in  = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(STATUS_NOT_FOUND, '0, count_ff);
                  end
               endcase
            end
         end
         S_SLOT_RD: begin
            state_in = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            if (slot_q_ff.valid) begin
               state_in = S_KEY_CHK;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_LOOKUP) begin
                  rsp_in = make_rsp(STATUS_NOT_FOUND, '0, count_ff);
               end else if (32'(count_ff) >= MAX_ENTRIES) begin
                  rsp_in = make_rsp(STATUS_FULL, '0, count_ff);
               end else begin
                  slot_we          = 1'b1;
                  slot_wdata.valid = 1'b1;
                  slot_wdata.entry = count_ff[ENTRY_W-1:0];
                  key_we           = 1'b1;
                  count_in         = count_ff + 1'b1;
                  rsp_in = make_rsp(STATUS_OK, count_ff[ENTRY_W-1:0], count_in);
               end
            end
         end
         S_KEY_CHK: begin
            if (entry_live && key_q_ff == key_ff) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_LOOKUP) begin
                  rsp_in = make_rsp(STATUS_OK, slot_q_ff.entry, count_ff);
               end else begin
                  rsp_in = make_rsp(STATUS_DUPLICATE, slot_q_ff.entry, count_ff);
               end
            end else if (32'(probe_cnt_ff) == TABLE_SLOTS - 1) begin
               // wrapped the whole table without an empty slot
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_LOOKUP) begin
                  rsp_in = make_rsp(STATUS_NOT_FOUND, '0, count_ff);
               end else begin
                  rsp_in = make_rsp(STATUS_FULL, '0, count_ff);
               end
            end else begin
               probe_cnt_in  = probe_cnt_ff + 1'b1;
               probe_slot_in = slot_step;
               state_in      = S_SLOT_RD;
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         probe_slot_ff <= '0;
         count_ff      <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         probe_slot_ff <= probe_slot_in;
         count_ff      <= count_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      probe_cnt_ff <= probe_cnt_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[probe_slot_ff] <= slot_wdata;
      end
      slot_q_ff <= slot_mem[probe_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[ENTRY_W-1:0]] <= key_ff;
      end
      key_q_ff <= key_mem[slot_q_ff.entry];
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- sim/lpht_checker.sv -----
// Response checker for the linear-probing hash table: predicts each response and compares.
`timescale 1ns / 1ps

module lpht_checker
   import lpht_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  rsp_type rsp_payload,
   output int      mismatch_count,
   output int      responses_due
);

   bit          slot_used [TABLE_SLOTS];
   int          slot_entry [TABLE_SLOTS];
   logic [31:0] key_mem [MAX_ENTRIES];
   int          entry_total;
   rsp_type     predicted_responses [$];
   int          errors;

   function automatic rsp_type hash_table_predict(req_type rq);
      rsp_type rs;
      int      home;
      int      s;
      int      e;
      bit      hit;
      int      hit_entry;
      hit       = 1'b0;
      hit_entry = 0;
      rs.status      = STATUS_NOT_FOUND;
      rs.entry_index = '0;
      home = int'(rq.key_hash % TABLE_SLOTS);
      if ((rq.cmd == CMD_LOOKUP || rq.cmd == CMD_INSERT) && entry_total > 0) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            s = (home + i) % TABLE_SLOTS;
            if (!slot_used[s]) break;
            e = slot_entry[s];
            if (e < entry_total && e < MAX_ENTRIES && key_mem[e] == rq.key_hash) begin
               hit       = 1'b1;
               hit_entry = e;
               break;
            end
         end
      end
      case (cmd_type'(rq.cmd))
         CMD_LOOKUP: begin
            if (hit) begin
               rs.status      = STATUS_OK;
               rs.entry_index = 4'(hit_entry);
            end
         end
         CMD_INSERT: begin
            if (hit) begin
               rs.status      = STATUS_DUPLICATE;
               rs.entry_index = 4'(hit_entry);
            end else begin
               rs.status = STATUS_FULL;
               if (entry_total < MAX_ENTRIES) begin
                  for (int i = 0; i < TABLE_SLOTS; i++) begin
                     s = (home + i) % TABLE_SLOTS;
                     if (!slot_used[s]) begin
                        slot_used[s]         = 1'b1;
                        slot_entry[s]        = entry_total;
                        key_mem[entry_total] = rq.key_hash;
                        rs.entry_index       = 4'(entry_total);
                        rs.status            = STATUS_OK;
                        entry_total++;
                        break;
                     end
                  end
               end
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               slot_used[i]  = 1'b0;
               slot_entry[i] = 0;
            end
            entry_total = 0;
            rs.status   = STATUS_OK;
         end
         default: ;
      endcase
      rs.entry_count = 5'(entry_total);
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_entry[i] = 0;
         end
         for (int i = 0; i < MAX_ENTRIES; i++) key_mem[i] = '0;
         entry_total = 0;
         predicted_responses.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_responses.size() == 0) begin
               $display("%0t: unexpected response status=%0d index=%0d count=%0d", $time,
                        rsp_payload.status, rsp_payload.entry_index, rsp_payload.entry_count);
               errors++;
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_payload.status);
                  errors++;
               end
               if (rsp_payload.entry_index !== want.entry_index) begin
                  $display("%0t: entry_index expected %0d actual %0d", $time,
                           want.entry_index, rsp_payload.entry_index);
                  errors++;
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $time,
                           want.entry_count, rsp_payload.entry_count);
                  errors++;
               end
            end
         end
         if (start && !busy) predicted_responses.push_back(hash_table_predict(req_payload));
      end
      mismatch_count <= errors;
      responses_due  <= predicted_responses.size();
   end

endmodule

// ----- sim/linear_probe_hash_table_top_test.sv -----
// Testbench top for the linear-probing hash table: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module linear_probe_hash_table_top_test
   import lpht_pkg::*;
();

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 850;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;
   int      mismatch_count;
   int      responses_due;
   int      stall_cycles = 0;

   logic [31:0] key_pool [$];

   always #2 clock = ~clock;

   linear_probe_hash_table_top DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   lpht_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic issue_request(input cmd_type c, input logic [31:0] k, input bit may_idle);
      req_type rq;
      rq.cmd      = c;
      rq.key_hash = k;
      while (may_idle && $urandom_range(0, 99) < 18) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (busy);
      if (c == CMD_INSERT) begin
         key_pool.push_back(k);
         if (key_pool.size() > 24) void'(key_pool.pop_front());
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (responses_due != 0);
   endtask

   // mix of known keys (hits, duplicates), keys homed near the wrap point, and random keys
   function automatic logic [31:0] pick_key();
      int          r;
      logic [31:0] k;
      r = $urandom_range(0, 99);
      k = $urandom;
      if (r < 40 && key_pool.size() > 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (r < 70) k[5:0] = 6'(60 + $urandom_range(0, 7));
      else if (r < 72) k = 32'h0000_0000;
      else if (r < 74) k = 32'hFFFF_FFFF;
      return k;
   endfunction

   initial begin
      int      r;
      bit      may_idle;
      cmd_type c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      issue_request(CMD_LOOKUP, 32'h0000_0000, 1'b1);
      issue_request(CMD_NOP,    32'hFFFF_FFFF, 1'b1);
      issue_request(CMD_INSERT, 32'h0000_0000, 1'b1);
      issue_request(CMD_INSERT, 32'hFFFF_FFFF, 1'b1);
      issue_request(CMD_INSERT, 32'h0000_0040, 1'b1);
      issue_request(CMD_INSERT, 32'h0000_0000, 1'b1);
      issue_request(CMD_LOOKUP, 32'h0000_0040, 1'b1);
      issue_request(CMD_LOOKUP, 32'h0000_0080, 1'b1);
      issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1);
      // same home slot as the all-ones key: long chains that wrap round
      for (int i = 1; i <= 13; i++) issue_request(CMD_INSERT, 32'(i * 64 + 63), 1'b1);
      issue_request(CMD_INSERT, 32'h1234_5678, 1'b1);
      issue_request(CMD_INSERT, 32'h0000_0040, 1'b1);
      issue_request(CMD_CLEAR,  32'hA5A5_A5A5, 1'b1);
      issue_request(CMD_LOOKUP, 32'h0000_0000, 1'b1);
      drain_responses();

      // random
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 46)      c = CMD_INSERT;
         else if (r < 94) c = CMD_LOOKUP;
         else if (r < 97) c = CMD_CLEAR;
         else             c = CMD_NOP;
         may_idle = !(n >= 300 && n < 480);
         issue_request(c, pick_key(), may_idle);
         if (n % 100 == 99) drain_responses();
      end

      drain_responses();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && responses_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
